@@ hw/rtl/mtfr_pkg.sv @@
package mtfr_pkg;

   localparam int DEF_MAX_ITEMS    = 1024;
   localparam int DEF_MAX_REQUESTS = 1024;
   localparam int DEF_TREE_NODES   = 4096;

   localparam int CFG_W   = 11;
   localparam int ITEM_W  = 11;
   localparam int RANK_W  = 10;
   localparam int CNT_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_COUNT = 2'd1;

   localparam logic CMD_RESTART = 1'b0;

   typedef enum logic {
      OP_RESTART = 1'b0,
      OP_ACCESS  = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ITEM_W-1:0]   item;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SLOT_WAIT,
      ST_Q_RD,
      ST_Q_ACC,
      ST_INC_RD,
      ST_INC_WR,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_RESULT
   } back_state_type;

endpackage

@@ hw/rtl/move_to_front_rank.sv @@
// Channel   Handshake               Payload
// req       req_valid / req_stall   req_cmd, req_item
// rsp       rsp_valid / rsp_stall   rsp_rank, rsp_error
// csr       csr_valid / csr_ready   csr_index, csr_wdata
//
// An access makes three tree walks, each at most log2(TREE_NODES) steps; every step reads
// through the registered read port, and increment and decrement steps also write back.
// A restart sweeps the tree and slot memories over max(TREE_NODES, MAX_ITEMS) addresses.
// An erroneous access goes straight to the result state. Reset is synchronous; no clearing pass.
// A two-entry request queue keeps accepting while the back end works or rsp is stalled, until full.
module move_to_front_rank #(
   parameter int MAX_ITEMS    = mtfr_pkg::DEF_MAX_ITEMS,
   parameter int MAX_REQUESTS = mtfr_pkg::DEF_MAX_REQUESTS,
   parameter int TREE_NODES   = mtfr_pkg::DEF_TREE_NODES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [mtfr_pkg::ITEM_W-1:0]    req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mtfr_pkg::RANK_W-1:0]    rsp_rank,
   output logic                           rsp_error,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mtfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtfr_pkg::CFG_W-1:0]     csr_wdata
);
   import mtfr_pkg::*;

   queue_head_type   head;
   logic             pop;
   logic             in_result;
   logic [CFG_W-1:0] item_count_ff, item_count_in;
   logic [CFG_W-1:0] request_count_ff, request_count_in;

   assign csr_ready = 1'b1;

   always_comb begin
      item_count_in    = item_count_ff;
      request_count_in = request_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ITEM_COUNT:    item_count_in    = csr_wdata;
            CSR_REQUEST_COUNT: request_count_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff    <= CFG_W'(1024);
         request_count_ff <= CFG_W'(1024);
      end else begin
         item_count_ff    <= item_count_in;
         request_count_ff <= request_count_in;
      end
   end

   mtfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_item  (req_item),
      .pop       (pop),
      .head      (head)
   );

   mtfr_back #(
      .MAX_ITEMS    (MAX_ITEMS),
      .MAX_REQUESTS (MAX_REQUESTS),
      .TREE_NODES   (TREE_NODES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .item_count    (item_count_ff),
      .request_count (request_count_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rank      (rsp_rank),
      .rsp_error     (rsp_error),
      .in_result     (in_result)
   );

   // A rejected access never reports a rank.
   a_error_rank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_rank == '0)
      else $error("error response carries a nonzero rank");

   // A new response only appears when the back end has finished an access.
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_result))
      else $error("response raised outside the result phase");

   // With the output register empty, a finished access is handed over at once.
   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      in_result && !rsp_valid |=> rsp_valid)
      else $error("finished access not moved into the output register");

endmodule

@@ hw/rtl/mtfr_ram.sv @@
module mtfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mtfr_front.sv @@
module mtfr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [mtfr_pkg::ITEM_W-1:0] req_item,
   input  logic                        pop,
   output mtfr_pkg::queue_head_type    head
);
   import mtfr_pkg::*;

   entry_type  entries_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   entry_type  new_entry;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      new_entry.op   = (req_cmd == CMD_RESTART) ? OP_RESTART : OP_ACCESS;
      new_entry.item = req_item;
   end

   always_comb begin
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = entries_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/mtfr_back.sv @@
module mtfr_back #(
   parameter int MAX_ITEMS    = mtfr_pkg::DEF_MAX_ITEMS,
   parameter int MAX_REQUESTS = mtfr_pkg::DEF_MAX_REQUESTS,
   parameter int TREE_NODES   = mtfr_pkg::DEF_TREE_NODES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mtfr_pkg::queue_head_type    head,
   output logic                        pop,
   input  logic [mtfr_pkg::CFG_W-1:0]  item_count,
   input  logic [mtfr_pkg::CFG_W-1:0]  request_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mtfr_pkg::RANK_W-1:0] rsp_rank,
   output logic                        rsp_error,
   output logic                        in_result
);
   import mtfr_pkg::*;

   localparam int N_W       = $clog2(MAX_ITEMS + 1);
   localparam int M_W       = $clog2(MAX_REQUESTS + 1);
   localparam int SLOT_W    = $clog2(MAX_ITEMS + MAX_REQUESTS + 1);
   localparam int WALK_W    = $clog2(TREE_NODES + MAX_ITEMS + MAX_REQUESTS + 1) + 1;
   localparam int TA_W      = $clog2(TREE_NODES);
   localparam int IA_W      = $clog2(MAX_ITEMS);
   localparam int SWEEP_LEN = (TREE_NODES > MAX_ITEMS) ? TREE_NODES : MAX_ITEMS;
   localparam int SW_W      = $clog2(SWEEP_LEN);

   back_state_type    state_ff, state_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [M_W-1:0]    m_ff, m_in;
   logic [M_W-1:0]    next_top_ff, next_top_in;
   logic [SW_W-1:0]   cnt_ff, cnt_in;
   logic [WALK_W-1:0] walk_ff, walk_in;
   logic [SLOT_W-1:0] old_slot_ff, old_slot_in;
   logic [IA_W-1:0]   item_idx_ff, item_idx_in;
   logic [RANK_W-1:0] sum_ff, sum_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic              rsp_error_ff, rsp_error_in;

   logic              tree_wr_en, tree_rd_en;
   logic [TA_W-1:0]   tree_wr_addr, tree_rd_addr;
   logic [CNT_W-1:0]  tree_wr_data, tree_rd_data;
   logic              slot_wr_en, slot_rd_en;
   logic [IA_W-1:0]   slot_wr_addr, slot_rd_addr;
   logic [SLOT_W-1:0] slot_wr_data, slot_rd_data;

   logic [WALK_W-1:0] walk_lsb;
   logic              walk_in_tree;
   logic              walk_live;
   logic              item_bad;
   logic              out_free;
   logic              sweep_last;
   logic [WALK_W-1:0] sw_s, sw_lo, sw_a, sw_b, sw_top, sw_m, sw_val;

   mtfr_ram #(.WIDTH(CNT_W), .DEPTH(TREE_NODES)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_wr_en),
      .wr_addr (tree_wr_addr),
      .wr_data (tree_wr_data),
      .rd_en   (tree_rd_en),
      .rd_addr (tree_rd_addr),
      .rd_data (tree_rd_data)
   );

   mtfr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ITEMS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   assign walk_lsb     = walk_ff & (~walk_ff + WALK_W'(1));
   assign walk_in_tree = (walk_ff < WALK_W'(TREE_NODES));
   assign walk_live    = (walk_ff != '0) && walk_in_tree;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign sweep_last   = (cnt_ff == SW_W'(SWEEP_LEN - 1));
   assign item_bad     = (head.entry.item == '0)
                      || (32'(head.entry.item) > 32'(n_ff))
                      || (next_top_ff == '0);

   // Node s of the tree covers slots (s - lowbit(s), s]; after a restart it holds
   // how many of the loaded slots M+1..M+N fall in that span.
   always_comb begin
      sw_s   = WALK_W'(cnt_ff);
      sw_lo  = sw_s - (sw_s & (~sw_s + WALK_W'(1)));
      sw_m   = WALK_W'(m_ff);
      sw_top = sw_m + WALK_W'(n_ff);
      sw_a   = (sw_lo > sw_m) ? sw_lo : sw_m;
      sw_b   = (sw_s < sw_top) ? sw_s : sw_top;
      sw_val = (sw_b > sw_a) ? (sw_b - sw_a) : '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (head.entry.op == OP_RESTART) begin
                  state_in = ST_SWEEP;
               end else if (item_bad) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SLOT_WAIT;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SLOT_WAIT: state_in = ST_Q_RD;
         ST_Q_RD: begin
            if (walk_ff == '0) begin
               state_in = ST_INC_RD;
            end else if (walk_in_tree) begin
               state_in = ST_Q_ACC;
            end
         end
         ST_Q_ACC:  state_in = ST_Q_RD;
         ST_INC_RD: state_in = walk_live ? ST_INC_WR : ST_DEC_RD;
         ST_INC_WR: state_in = ST_INC_RD;
         ST_DEC_RD: state_in = walk_live ? ST_DEC_WR : ST_RESULT;
         ST_DEC_WR: state_in = ST_DEC_RD;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      n_in         = n_ff;
      m_in         = m_ff;
      next_top_in  = next_top_ff;
      cnt_in       = cnt_ff;
      walk_in      = walk_ff;
      old_slot_in  = old_slot_ff;
      item_idx_in  = item_idx_ff;
      sum_in       = sum_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rank_in  = rsp_rank_ff;
      rsp_error_in = rsp_error_ff;
      tree_wr_en   = 1'b0;
      tree_wr_addr = walk_ff[TA_W-1:0];
      tree_wr_data = tree_rd_data + CNT_W'(1);
      tree_rd_en   = 1'b0;
      tree_rd_addr = walk_ff[TA_W-1:0];
      slot_wr_en   = 1'b0;
      slot_wr_addr = item_idx_ff;
      slot_wr_data = SLOT_W'(next_top_ff);
      slot_rd_en   = 1'b0;
      slot_rd_addr = IA_W'(head.entry.item - ITEM_W'(1));
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.op == OP_RESTART) begin
                  n_in   = (32'(item_count) > MAX_ITEMS) ? N_W'(MAX_ITEMS)
                                                         : N_W'(item_count);
                  m_in   = (32'(request_count) > MAX_REQUESTS) ? M_W'(MAX_REQUESTS)
                                                               : M_W'(request_count);
                  cnt_in = '0;
               end else if (item_bad) begin
                  err_in = 1'b1;
                  sum_in = '0;
               end else begin
                  slot_rd_en  = 1'b1;
                  item_idx_in = slot_rd_addr;
                  err_in      = 1'b0;
                  sum_in      = '0;
               end
            end
         end
         ST_SWEEP: begin
            tree_wr_en   = (WALK_W'(cnt_ff) < WALK_W'(TREE_NODES));
            tree_wr_addr = cnt_ff[TA_W-1:0];
            tree_wr_data = sw_val[CNT_W-1:0];
            slot_wr_en   = (WALK_W'(cnt_ff) < WALK_W'(n_ff));
            slot_wr_addr = cnt_ff[IA_W-1:0];
            slot_wr_data = SLOT_W'(WALK_W'(m_ff) + WALK_W'(cnt_ff) + WALK_W'(1));
            cnt_in       = cnt_ff + SW_W'(1);
            if (sweep_last) begin
               next_top_in = m_ff;
            end
         end
         ST_SLOT_WAIT: begin
            old_slot_in = slot_rd_data;
            walk_in     = (slot_rd_data == '0) ? '0
                                               : WALK_W'(slot_rd_data) - WALK_W'(1);
         end
         ST_Q_RD: begin
            if (walk_ff == '0) begin
               walk_in = WALK_W'(next_top_ff);
            end else if (walk_in_tree) begin
               tree_rd_en = 1'b1;
            end else begin
               walk_in = walk_ff - walk_lsb;
            end
         end
         ST_Q_ACC: begin
            sum_in  = sum_ff + tree_rd_data[RANK_W-1:0];
            walk_in = walk_ff - walk_lsb;
         end
         ST_INC_RD: begin
            if (walk_live) begin
               tree_rd_en = 1'b1;
            end else begin
               walk_in = WALK_W'(old_slot_ff);
            end
         end
         ST_INC_WR: begin
            tree_wr_en = 1'b1;
            walk_in    = walk_ff + walk_lsb;
         end
         ST_DEC_RD: begin
            if (walk_live) begin
               tree_rd_en = 1'b1;
            end else begin
               slot_wr_en  = 1'b1;
               next_top_in = next_top_ff - M_W'(1);
            end
         end
         ST_DEC_WR: begin
            tree_wr_en   = 1'b1;
            tree_wr_data = tree_rd_data - CNT_W'(1);
            walk_in      = walk_ff + walk_lsb;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rank_in  = sum_ff;
               rsp_error_in = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         m_ff         <= '0;
         next_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         m_ff         <= m_in;
         next_top_ff  <= next_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      walk_ff      <= walk_in;
      old_slot_ff  <= old_slot_in;
      item_idx_ff  <= item_idx_in;
      sum_ff       <= sum_in;
      err_ff       <= err_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rank  = rsp_rank_ff;
   assign rsp_error = rsp_error_ff;
   assign in_result = (state_ff == ST_RESULT);

endmodule

@@ tb/move_to_front_rank_tb.sv @@
`timescale 1ns / 1ps

module move_to_front_rank_tb;
   import mtfr_pkg::*;

   localparam int SETTLE_CYCLES = 12500;
   localparam int CYCLE_LIMIT   = 8000000;
   localparam int SLOT_SPAN     = 4096;

   typedef struct {
      op_type            op;
      logic [ITEM_W-1:0] item;
   } request_type;

   typedef struct {
      logic [RANK_W-1:0] rank;
      logic              error;
   } answer_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_cmd;
   logic [ITEM_W-1:0] req_item;
   logic rsp_valid;
   logic rsp_stall;
   logic [RANK_W-1:0] rsp_rank;
   logic rsp_error;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   request_type pending_reqs[$];
   answer_type  expected_answers[$];

   // Shadow of the ranker: which slots hold an item and where each item sits.
   bit          slot_busy[SLOT_SPAN];
   int unsigned item_slot[1:1024];
   int unsigned top_slot;
   int unsigned live_n;
   int unsigned live_m;
   int unsigned reg_n;
   int unsigned reg_m;

   int  mismatches;
   int  cycle_count;
   bit  req_taken;
   bit  steady_phase;
   bit  start_hold;
   int  hold_left;
   int  req_gap;

   move_to_front_rank uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_phase || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void predict_request(request_type r);
      answer_type a;
      int unsigned old_slot;
      int unsigned count;
      if (r.op == OP_RESTART) begin
         live_n = (reg_n > DEF_MAX_ITEMS) ? DEF_MAX_ITEMS : reg_n;
         live_m = (reg_m > DEF_MAX_REQUESTS) ? DEF_MAX_REQUESTS : reg_m;
         foreach (slot_busy[s]) slot_busy[s] = 1'b0;
         for (int i = 1; i <= live_n; i++) begin
            slot_busy[live_m + i] = 1'b1;
            item_slot[i] = live_m + i;
         end
         top_slot = live_m;
         return;
      end
      if (r.item == 0 || r.item > live_n || top_slot == 0) begin
         a.rank = '0;
         a.error = 1'b1;
      end else begin
         old_slot = item_slot[r.item];
         count = 0;
         for (int s = 1; s < old_slot; s++) count += slot_busy[s];
         slot_busy[top_slot] = 1'b1;
         slot_busy[old_slot] = 1'b0;
         item_slot[r.item] = top_slot;
         top_slot--;
         a.rank = count[RANK_W-1:0];
         a.error = 1'b0;
      end
      expected_answers.push_back(a);
   endfunction

   // Accept and predict at the rising edge.
   always @(posedge clock) begin
      request_type r;
      if (!reset && req_valid && !req_stall) begin
         r.op = op_type'(req_cmd);
         r.item = req_item;
         predict_request(r);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_cmd <= r.op;
            req_item <= r.item;
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with one long hold-off on request. The hold outlasts a restart
   // sweep so that finished accesses back up into the request queue.
   always @(negedge clock) begin
      int r;
      if (start_hold) begin
         start_hold = 1'b0;
         hold_left = 6000;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (steady_phase) begin
         rsp_stall <= 1'b0;
      end else if (r < 25) begin
         rsp_stall <= 1'b1;
      end else if (r < 27) begin
         hold_left = $urandom_range(10, 40);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: rank %0d error %0b", rsp_rank, rsp_error);
         end else begin
            e = expected_answers.pop_front();
            if (rsp_rank !== e.rank || rsp_error !== e.error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected rank %0d error %0b, got rank %0d error %0b",
                           e.rank, e.error, rsp_rank, rsp_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_answers.size() > 0);
      // Restarts give no result; up to three may still be queued or sweeping.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_W-1:0];
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_ITEM_COUNT) reg_n = value & 'h7FF;
      else reg_m = value & 'h7FF;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_req(op_type op, int unsigned item);
      request_type r;
      r.op = op;
      r.item = item[ITEM_W-1:0];
      pending_reqs.push_back(r);
   endtask

   task automatic configure(int unsigned n, int unsigned m);
      wait_idle();
      write_reg(CSR_ITEM_COUNT, n);
      write_reg(CSR_REQUEST_COUNT, m);
   endtask

   function automatic int unsigned pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 40);
      if (r < 85) return $urandom_range(41, 300);
      if (r < 92) return $urandom_range(1024, 2047);
      if (r < 96) return 0;
      return $urandom_range(301, 1023);
   endfunction

   initial begin
      int issued;
      int burst;
      int r;
      int unsigned n;
      int unsigned lim;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = OP_RESTART;
      req_item = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ITEM_COUNT;
      csr_wdata = '0;
      mismatches = 0;
      cycle_count = 0;
      req_taken = 1'b0;
      steady_phase = 1'b0;
      start_hold = 1'b0;
      hold_left = 0;
      reg_n = 1024;
      reg_m = 1024;
      live_n = 0;
      live_m = 0;
      top_slot = 0;
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Accesses before any restart must all fail.
      push_req(OP_ACCESS, 1);
      push_req(OP_ACCESS, 0);
      push_req(OP_ACCESS, 2047);

      // Small stack with three top slots: out-of-range items and exhaustion.
      configure(5, 3);
      push_req(OP_RESTART, 0);
      push_req(OP_ACCESS, 5);
      push_req(OP_ACCESS, 0);
      push_req(OP_ACCESS, 6);
      push_req(OP_ACCESS, 1);
      push_req(OP_ACCESS, 5);
      push_req(OP_ACCESS, 3);
      push_req(OP_ACCESS, 2);

      // Saturated registers give the full stack.
      configure(2047, 2047);
      push_req(OP_RESTART, 2047);
      push_req(OP_ACCESS, 1024);
      push_req(OP_ACCESS, 1);
      push_req(OP_ACCESS, 1024);
      push_req(OP_ACCESS, 1025);
      push_req(OP_ACCESS, 2047);
      push_req(OP_ACCESS, 512);

      // No top slots at all.
      configure(1, 0);
      push_req(OP_RESTART, 0);
      push_req(OP_ACCESS, 1);

      issued = 0;
      while (issued < 1620) begin
         n = pick_size();
         configure(n, pick_size());
         steady_phase = ($urandom_range(0, 5) == 0);
         if (issued == 0) start_hold = 1'b1;
         push_req(OP_RESTART, $urandom_range(0, 2047));
         // Writes between restarts only take effect at the next restart.
         burst = $urandom_range(20, 120);
         n = (n > 1024) ? 1024 : n;
         for (int k = 0; k < burst; k++) begin
            r = $urandom_range(0, 99);
            lim = (n == 0) ? 1 : n;
            if (r < 2) push_req(OP_RESTART, $urandom_range(0, 2047));
            else if (r < 8) push_req(OP_ACCESS, $urandom_range(0, 2047));
            else if (r < 30) push_req(OP_ACCESS, $urandom_range(1, (lim < 4) ? lim : 4));
            else push_req(OP_ACCESS, $urandom_range(1, lim));
         end
         issued += burst + 1;
      end

      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_answers.size() > 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
